FILE: src/sbc2u8_pkg.sv
package sbc2u8_pkg;

    // Source character sets selected by the source_set register.
    localparam logic [1:0] SRC_LATIN1 = 2'd0;
    localparam logic [1:0] SRC_ISO5   = 2'd1;
    localparam logic [1:0] SRC_EBCDIC = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_SOURCE_SET   = 1'b0;
    localparam logic CFG_OUT_CAPACITY = 1'b1;

    localparam logic [1:0]  SOURCE_SET_RESET   = SRC_LATIN1;
    localparam logic [15:0] OUT_CAPACITY_RESET = 16'hFFFF;

    // UTF-8 encoding constants.
    localparam logic [15:0] CP_MAX1     = 16'h007F;
    localparam logic [15:0] CP_MAX2     = 16'h07FF;
    localparam logic [7:0]  UTF8_LEAD2  = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3  = 8'hE0;
    localparam logic [7:0]  UTF8_CONT   = 8'h80;

    localparam logic [15:0] ISO5_NUMERO = 16'h2116;
    localparam logic [15:0] ISO5_OFFSET = 16'h0360;
    localparam logic [7:0]  ISO5_NUMERO_BYTE = 8'hF0;
    localparam logic [7:0]  ISO5_FIRST_SHIFT = 8'hA1;

    // Result status, also used as the halt reason.
    typedef enum logic [1:0] {
        ST_DATA     = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_TRUNC    = 2'd2
    } t_status;

    // Encoded character: up to three UTF-8 bytes and their number.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      n;
    } t_enc;

    localparam logic [7:0] EBC_MID [64] = '{
        8'h20, 8'hA0, 8'hE2, 8'hE4, 8'hE0, 8'hE1, 8'hE3, 8'hE5,
        8'hE7, 8'hF1, 8'hA2, 8'h2E, 8'h3C, 8'h28, 8'h2B, 8'h7C,
        8'h26, 8'hE9, 8'hEA, 8'hEB, 8'hE8, 8'hED, 8'hEE, 8'hEF,
        8'hEC, 8'hC4, 8'hC5, 8'hC9, 8'hB6, 8'hC6, 8'hF4, 8'hF6,
        8'hF2, 8'hFB, 8'hF9, 8'hFF, 8'hD6, 8'hDC, 8'hA2, 8'hA3,
        8'hA5, 8'h7E, 8'hB7, 8'hAF, 8'h60, 8'h27, 8'h3D, 8'h5E,
        8'hFF, 8'hF3, 8'hFA, 8'hA1, 8'hB5, 8'hB7, 8'hAA, 8'hAB,
        8'hAC, 8'hBD, 8'hBC, 8'hA1, 8'hAB, 8'hBB, 8'h3F, 8'h3F
    };

    localparam logic [7:0] EBC_TOP [32] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F, 8'h3F,
        8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48,
        8'h49, 8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h3F
    };

    // Every EBCDIC code point of this table fits in eight bits.
    function automatic logic [7:0] ebcdic_cp(input logic [7:0] b);
        logic [7:0] cp;
        if (b < 8'h40) begin
            cp = b;
        end else if (b < 8'h80) begin
            cp = EBC_MID[b[5:0]];
        end else if (b < 8'hE0) begin
            cp = b + 8'h20;
        end else begin
            cp = EBC_TOP[b[4:0]];
        end
        return cp;
    endfunction

    function automatic logic [15:0] iso5_cp(input logic [7:0] b);
        logic [15:0] cp;
        if (b == ISO5_NUMERO_BYTE) begin
            cp = ISO5_NUMERO;
        end else if (b >= ISO5_FIRST_SHIFT) begin
            cp = {8'h00, b} + ISO5_OFFSET;
        end else begin
            cp = {8'h00, b};
        end
        return cp;
    endfunction

endpackage

FILE: src/sbc2u8_encode.sv
module sbc2u8_encode (
    input  logic [1:0]       i_source_set,
    input  logic [7:0]       i_byte,
    output sbc2u8_pkg::t_enc o_enc
);

    logic [15:0] cp;

    always_comb begin
        unique case (i_source_set)
            sbc2u8_pkg::SRC_ISO5:   cp = sbc2u8_pkg::iso5_cp(i_byte);
            sbc2u8_pkg::SRC_EBCDIC: cp = {8'h00, sbc2u8_pkg::ebcdic_cp(i_byte)};
            default:                cp = {8'h00, i_byte};
        endcase
    end

    always_comb begin
        o_enc = '0;
        if (cp <= sbc2u8_pkg::CP_MAX1) begin
            o_enc.n        = 2'd1;
            o_enc.bytes[0] = cp[7:0];
        end else if (cp <= sbc2u8_pkg::CP_MAX2) begin
            o_enc.n        = 2'd2;
            o_enc.bytes[0] = sbc2u8_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]};
            o_enc.bytes[1] = sbc2u8_pkg::UTF8_CONT | {2'b00, cp[5:0]};
        end else begin
            o_enc.n        = 2'd3;
            o_enc.bytes[0] = sbc2u8_pkg::UTF8_LEAD3 | {4'h0, cp[15:12]};
            o_enc.bytes[1] = sbc2u8_pkg::UTF8_CONT | {2'b00, cp[11:6]};
            o_enc.bytes[2] = sbc2u8_pkg::UTF8_CONT | {2'b00, cp[5:0]};
        end
    end

endmodule

FILE: src/single_byte_charset_to_utf8_core.sv
// Channel   Direction  Handshake              Payload
// input     in         i_valid / o_stall      i_in_byte, i_in_last
// result    out        o_valid / i_stall      o_out_byte, o_run_last, o_status,
//                                             o_string_end, o_byte_count
// config    in         i_cfg_we               i_cfg_index, i_cfg_data
//
// A transaction goes into an input register, is translated and checked against the
// capacity combinationally, and lands in a result buffer of up to three UTF-8 bytes.
// The single result port sets the rate: one result per cycle while i_stall is low;
// ASCII and status-only transactions give one result, wider characters two or three.
// Results appear at the earliest once the input register has loaded the result buffer.
// Reset is synchronous, active low; it clears both registers, the byte count and
// the halt state. A stall on the result side holds the buffer, then the input
// register, and only then raises o_stall.
module single_byte_charset_to_utf8_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic [1:0]  o_status,
    output logic        o_string_end,
    output logic [15:0] o_byte_count
);

    localparam logic [32:0] CountMax = 33'((64'd1 << COUNT_WIDTH) - 64'd1);

    logic [1:0]  r_source_set;
    logic [15:0] r_out_capacity;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    logic [COUNT_WIDTH-1:0] r_pos;
    sbc2u8_pkg::t_status    r_halt;

    logic                   r_buf_valid;
    logic [1:0]             r_idx;
    logic [2:0][7:0]        r_bytes;
    logic [1:0]             r_n;
    sbc2u8_pkg::t_status    r_status;
    logic                   r_last;
    logic [COUNT_WIDTH-1:0] r_cnt0;

    logic [COUNT_WIDTH-1:0] n_pos;
    sbc2u8_pkg::t_status    n_halt;
    logic [2:0][7:0]        n_bytes;
    logic [1:0]             n_n;
    sbc2u8_pkg::t_status    n_status;
    logic [COUNT_WIDTH-1:0] n_cnt0;

    sbc2u8_pkg::t_enc       enc;
    logic                   is_latin;
    logic [32:0]            cap_w;
    logic [32:0]            limit_w;
    logic [32:0]            pos_w;
    logic [32:0]            need_w;
    logic                   in_accept;
    logic                   out_accept;
    logic                   run_end;
    logic                   buf_done;
    logic                   buf_load;
    logic [COUNT_WIDTH-1:0] cnt;
    logic [31:0]            cnt32;

    sbc2u8_encode u_encode (
        .i_source_set (r_source_set),
        .i_byte       (r_in_byte),
        .o_enc        (enc)
    );

    assign run_end    = (r_idx == r_n - 2'd1);
    assign out_accept = r_buf_valid && !i_stall;
    assign buf_done   = out_accept && run_end;
    assign buf_load   = r_in_valid && (!r_buf_valid || buf_done);
    assign o_stall    = r_in_valid && !buf_load;
    assign in_accept  = i_valid && !o_stall;

    assign is_latin = (r_source_set != sbc2u8_pkg::SRC_ISO5)
                   && (r_source_set != sbc2u8_pkg::SRC_EBCDIC);
    assign cap_w    = 33'(r_out_capacity);
    assign limit_w  = (cap_w < CountMax) ? cap_w : CountMax;
    assign pos_w    = 33'(r_pos);
    assign need_w   = pos_w + 33'(enc.n);

    always_comb begin
        n_pos    = r_pos;
        n_halt   = r_halt;
        n_bytes  = '0;
        n_n      = 2'd1;
        n_status = r_halt;
        n_cnt0   = (r_halt == sbc2u8_pkg::ST_OVERFLOW) ? '0 : r_pos;
        if (r_halt == sbc2u8_pkg::ST_DATA) begin
            // Latin-1 drops bytes with a truncation status once the buffer is full.
            if (is_latin && (pos_w >= limit_w)) begin
                n_status = sbc2u8_pkg::ST_TRUNC;
                n_halt   = sbc2u8_pkg::ST_TRUNC;
                n_cnt0   = r_pos;
            end else if (need_w > limit_w) begin
                n_status = sbc2u8_pkg::ST_OVERFLOW;
                n_halt   = sbc2u8_pkg::ST_OVERFLOW;
                n_cnt0   = '0;
            end else begin
                n_status = sbc2u8_pkg::ST_DATA;
                n_bytes  = enc.bytes;
                n_n      = enc.n;
                n_cnt0   = r_pos + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
                n_pos    = need_w[COUNT_WIDTH-1:0];
            end
        end
        if (r_in_last) begin
            n_pos  = '0;
            n_halt = sbc2u8_pkg::ST_DATA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_set   <= sbc2u8_pkg::SOURCE_SET_RESET;
            r_out_capacity <= sbc2u8_pkg::OUT_CAPACITY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sbc2u8_pkg::CFG_SOURCE_SET:   r_source_set   <= i_cfg_data[1:0];
                sbc2u8_pkg::CFG_OUT_CAPACITY: r_out_capacity <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (buf_load) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_halt      <= sbc2u8_pkg::ST_DATA;
            r_buf_valid <= 1'b0;
            r_idx       <= 2'd0;
        end else if (buf_load) begin
            r_pos       <= n_pos;
            r_halt      <= n_halt;
            r_buf_valid <= 1'b1;
            r_idx       <= 2'd0;
        end else if (buf_done) begin
            r_buf_valid <= 1'b0;
        end else if (out_accept) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (buf_load) begin
            r_bytes  <= n_bytes;
            r_n      <= n_n;
            r_status <= n_status;
            r_last   <= r_in_last;
            r_cnt0   <= n_cnt0;
        end
    end

    assign cnt   = r_cnt0 + COUNT_WIDTH'(r_idx);
    assign cnt32 = 32'(cnt);

    assign o_valid      = r_buf_valid;
    assign o_out_byte   = r_bytes[r_idx];
    assign o_run_last   = run_end;
    assign o_status     = r_status;
    assign o_string_end = r_last && run_end;
    assign o_byte_count = cnt32[15:0];

    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buf_valid |-> (r_idx < r_n))
        else $error("result index beyond the buffered run");

    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_buf_valid && (r_status != sbc2u8_pkg::ST_DATA)) |-> (r_n == 2'd1))
        else $error("status result is not a single result");

    a_string_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (buf_load && r_in_last) |=> ((r_pos == '0) && (r_halt == sbc2u8_pkg::ST_DATA)))
        else $error("end of string did not clear count and halt");

    a_overflow_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == sbc2u8_pkg::ST_OVERFLOW)) |-> (o_byte_count == 16'd0))
        else $error("overflow result carries a nonzero count");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_buf_valid))
        else $error("input stalled with room to take a transaction");

endmodule
